// ----- rtl/palette_nearest_color_map_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the palette nearest colour mapper
// Shared concurrent assertion forms, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef PALETTE_NEAREST_COLOR_MAP_CORE_ASSERT_SVH
`define PALETTE_NEAREST_COLOR_MAP_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define PNCM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PNCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pncm_pkg.sv -----
// ----------------------------------------------------------------------------
// pncm_pkg
// Types and constants shared by the palette nearest colour mapper.
// ----------------------------------------------------------------------------
package pncm_pkg;

  // Request operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  // Weight of the alpha term: 255*255+1
  localparam logic [16:0] ALPHA_WEIGHT = 17'd65026;

  // Starting value of the running minimum
  localparam logic [31:0] DIST_INIT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Steps of the shared multiplier for one palette entry
  typedef enum logic [3:0] {
    PH_W,
    PH_SQA,
    PH_MULA,
    PH_SQR,
    PH_MULR,
    PH_SQG,
    PH_MULG,
    PH_SQB,
    PH_MULB,
    PH_SUM
  } phase_e;

  typedef struct packed {
    logic busy;
    logic done;
  } dist_stat_t;

endpackage

// ----- rtl/pncm_if.sv -----
// ----------------------------------------------------------------------------
// pncm request and response channels
// Valid/ready channels carrying the mapper's request and result payloads.
// ----------------------------------------------------------------------------
interface pncm_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  entry_index;
  logic [31:0] argb_value;

  modport source (output valid, operation, entry_index, argb_value, input ready);
  modport sink (input valid, operation, entry_index, argb_value, output ready);
endinterface

interface pncm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] best_index;

  modport source (output valid, best_index, input ready);
  modport sink (input valid, best_index, output ready);
endinterface

// ----- rtl/pncm_dist_unit.sv -----
// ----------------------------------------------------------------------------
// pncm_dist_unit
// Weighted ARGB distance over ten steps of one shared 17x17 multiplier.
// ----------------------------------------------------------------------------
`include "palette_nearest_color_map_core_assert.svh"

module pncm_dist_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [31:0]           pixel_i,
  input  logic [31:0]           entry_i,
  output pncm_pkg::dist_stat_t  stat_o,
  output logic [31:0]           dist_o
);

  pncm_pkg::phase_e phase_q, phase_d;
  logic             busy_q, busy_d;

  logic [31:0] prod_q, prod_d;
  logic [31:0] acc_q, acc_d;
  logic [16:0] w_q, w_d;

  logic [7:0]  byte_p, byte_e, diff;
  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_full;
  logic [31:0] term;

  // Sequencer next state
  always_comb begin
    phase_d = phase_q;
    busy_d  = busy_q;
    if (start_i) begin
      phase_d = pncm_pkg::PH_W;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      unique case (phase_q)
        pncm_pkg::PH_W:    phase_d = pncm_pkg::PH_SQA;
        pncm_pkg::PH_SQA:  phase_d = pncm_pkg::PH_MULA;
        pncm_pkg::PH_MULA: phase_d = pncm_pkg::PH_SQR;
        pncm_pkg::PH_SQR:  phase_d = pncm_pkg::PH_MULR;
        pncm_pkg::PH_MULR: phase_d = pncm_pkg::PH_SQG;
        pncm_pkg::PH_SQG:  phase_d = pncm_pkg::PH_MULG;
        pncm_pkg::PH_MULG: phase_d = pncm_pkg::PH_SQB;
        pncm_pkg::PH_SQB:  phase_d = pncm_pkg::PH_MULB;
        pncm_pkg::PH_MULB: phase_d = pncm_pkg::PH_SUM;
        pncm_pkg::PH_SUM:  busy_d  = 1'b0;
        default:           busy_d  = 1'b0;
      endcase
    end
  end

  // Sequencer outputs: operand selection
  always_comb begin
    byte_p = pixel_i[31:24];
    byte_e = entry_i[31:24];
    unique case (phase_q)
      pncm_pkg::PH_SQR: begin
        byte_p = pixel_i[23:16];
        byte_e = entry_i[23:16];
      end
      pncm_pkg::PH_SQG: begin
        byte_p = pixel_i[15:8];
        byte_e = entry_i[15:8];
      end
      pncm_pkg::PH_SQB: begin
        byte_p = pixel_i[7:0];
        byte_e = entry_i[7:0];
      end
      default: ;
    endcase
  end

  assign diff = (byte_p > byte_e) ? (byte_p - byte_e) : (byte_e - byte_p);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (phase_q) inside
      pncm_pkg::PH_W: begin
        mul_a = {9'd0, pixel_i[31:24]};
        mul_b = {9'd0, entry_i[31:24]};
      end
      pncm_pkg::PH_SQA, pncm_pkg::PH_SQR,
      pncm_pkg::PH_SQG, pncm_pkg::PH_SQB: begin
        mul_a = {9'd0, diff};
        mul_b = {9'd0, diff};
      end
      pncm_pkg::PH_MULA: begin
        mul_a = prod_q[16:0];
        mul_b = pncm_pkg::ALPHA_WEIGHT;
      end
      pncm_pkg::PH_MULR, pncm_pkg::PH_MULG, pncm_pkg::PH_MULB: begin
        mul_a = prod_q[16:0];
        mul_b = w_q;
      end
      default: ;
    endcase
  end

  // Every product here stays below 2^32
  assign mul_full = mul_a * mul_b;
  assign prod_d   = mul_full[31:0];
  assign term     = {2'b00, prod_q[31:2]};

  always_comb begin
    acc_d = acc_q;
    w_d   = w_q;
    case (phase_q) inside
      pncm_pkg::PH_SQA: w_d   = prod_q[16:0] + 17'd1;
      pncm_pkg::PH_SQR: acc_d = term;
      pncm_pkg::PH_SQG,
      pncm_pkg::PH_SQB: acc_d = acc_q + term;
      default: ;
    endcase
  end

  assign dist_o      = acc_q + term;
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (phase_q == pncm_pkg::PH_SUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pncm_pkg::PH_W;
      busy_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    w_q    <= w_d;
  end

  `PNCM_ASSERT_NEXT(a_start_arms_seq, clk_i, rst_ni, start_i,
                    busy_q && (phase_q == pncm_pkg::PH_W), "sequencer did not restart")

endmodule

// ----- rtl/palette_nearest_color_map_core.sv -----
// ----------------------------------------------------------------------------
// palette_nearest_color_map_core
// Nearest palette colour search for 32-bit ARGB pixels, alpha weighted.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries requests: operation, entry_index and argb_value. A write
//   request stores argb_value in palette slot entry_index (slots at or above
//   PALETTE_ENTRIES are dropped); it gives no result.
//   A map request scans the whole palette and returns on rsp_o the lowest
//   index at the smallest weighted distance.
//   Each palette entry is launched into the distance unit, which then runs
//   ten steps of its single shared multiplier. ready is low during the scan.
//   The result sits in an output register, so further requests are taken
//   while it waits; a second map stalls at its end only if the earlier
//   result has still not been taken.
//   Reset clears the palette to zero at once through per-slot valid bits;
//   the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "palette_nearest_color_map_core_assert.svh"

module palette_nearest_color_map_core #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pncm_req_if.sink          req_i,
  pncm_rsp_if.source        rsp_o
);

  localparam int unsigned     IdxW      = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(PALETTE_ENTRIES - 1);
  localparam logic [8:0]      SlotLimit = 9'(PALETTE_ENTRIES);

  pncm_pkg::state_e state_q, state_d;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     best_dist_q, best_dist_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            out_valid_q, out_valid_d;
  logic [IdxW-1:0] out_idx_q;
  logic [31:0]     pixel_q;

  // Palette memory plus valid bits; an unwritten slot reads as zero
  logic [31:0]                mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] vld_q;
  logic [31:0]                rd_data_q;
  logic                       rd_vld_q;
  logic [31:0]                entry;

  logic            req_accept, map_accept, wr_accept;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic            rd_en;
  logic            dist_start, load_out, update;
  logic [31:0]     entry_dist;

  pncm_pkg::dist_stat_t dist_stat;

  assign req_accept = req_i.valid && req_i.ready;
  assign map_accept = req_accept && (req_i.operation == pncm_pkg::OP_MAP);
  // Drop writes to slots beyond the palette
  assign wr_accept  = req_accept && (req_i.operation == pncm_pkg::OP_WRITE) &&
                      ({1'b0, req_i.entry_index} < SlotLimit);
  assign wr_addr    = req_i.entry_index[IdxW-1:0];

  // Fetch slot zero when a map request lands, then the next slot as each
  // distance completes
  assign rd_en   = map_accept || (dist_stat.done && (idx_q != LastIdx));
  assign rd_addr = map_accept ? '0 : (idx_q + IdxW'(1));
  assign entry   = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (wr_accept) begin
      mem[wr_addr] <= req_i.argb_value;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_accept) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  pncm_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .pixel_i (pixel_q),
    .entry_i (entry),
    .stat_o  (dist_stat),
    .dist_o  (entry_dist)
  );

  // Strict compare keeps the lowest index on a tie
  assign update = dist_stat.done && (entry_dist < best_dist_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pncm_pkg::ST_IDLE: begin
        if (map_accept) state_d = pncm_pkg::ST_START;
      end
      pncm_pkg::ST_START: state_d = pncm_pkg::ST_SCAN;
      pncm_pkg::ST_SCAN: begin
        if (dist_stat.done) begin
          state_d = (idx_q == LastIdx) ? pncm_pkg::ST_FINISH : pncm_pkg::ST_START;
        end
      end
      pncm_pkg::ST_FINISH: begin
        if (!out_valid_q || rsp_o.ready) state_d = pncm_pkg::ST_IDLE;
      end
      default: state_d = pncm_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req_i.ready = 1'b0;
    dist_start  = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      pncm_pkg::ST_IDLE:   req_i.ready = 1'b1;
      pncm_pkg::ST_START:  dist_start  = 1'b1;
      pncm_pkg::ST_SCAN:   ;
      pncm_pkg::ST_FINISH: load_out    = !out_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  // Scan bookkeeping
  always_comb begin
    idx_d       = idx_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    if (map_accept) begin
      idx_d       = '0;
      best_dist_d = pncm_pkg::DIST_INIT;
      best_idx_d  = '0;
    end else begin
      if (dist_stat.done && (idx_q != LastIdx)) idx_d = idx_q + IdxW'(1);
      if (update) begin
        best_dist_d = entry_dist;
        best_idx_d  = idx_q;
      end
    end
  end

  // Hold the result until taken; a fresh one may load on the take cycle
  assign out_valid_d = load_out || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pncm_pkg::ST_IDLE;
      idx_q       <= '0;
      best_dist_q <= pncm_pkg::DIST_INIT;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      best_dist_q <= best_dist_d;
      best_idx_q  <= best_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_accept) pixel_q   <= req_i.argb_value;
    if (load_out)   out_idx_q <= best_idx_q;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.best_index = 8'(out_idx_q);

  `PNCM_ASSERT_SAME(a_start_unit_idle, clk_i, rst_ni, dist_start, !dist_stat.busy,
                    "distance unit restarted while busy")
  `PNCM_ASSERT_SAME(a_done_in_scan, clk_i, rst_ni, dist_stat.done,
                    state_q == pncm_pkg::ST_SCAN, "distance done outside scan")
  `PNCM_ASSERT_SAME(a_best_monotone, clk_i, rst_ni,
                    (state_q != pncm_pkg::ST_IDLE) && ($past(state_q) != pncm_pkg::ST_IDLE),
                    best_dist_q <= $past(best_dist_q), "best distance grew during scan")
  `PNCM_ASSERT_SAME(a_result_from_finish, clk_i, rst_ni, $rose(rsp_o.valid),
                    $past(state_q) == pncm_pkg::ST_FINISH, "result raised outside finish")

endmodule
